>>> rtl/assert_macros.svh
// assertion macros shared by the biquad section rtl
// no dependencies; include once per file that checks properties
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define BQF_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define BQF_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bqf_pkg.sv
// shared widths, types and codes for the biquad filter section
// no dependencies; compiled before every module of the block
`timescale 1ns / 1ps

package bqf_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 16;
    localparam int DIGIT_W     = 4;
    localparam int NUM_DIGITS  = SAMPLE_W / DIGIT_W;
    localparam int DIGIT_CNT_W = $clog2(NUM_DIGITS);
    localparam int TERM_W      = 3;
    // coefficient with room for negation
    localparam int NCOEF_W     = COEF_W + 1;
    localparam int PP_W        = NCOEF_W + DIGIT_W + 1;
    localparam int PROD_W      = NCOEF_W + SAMPLE_W;
    // five terms need three guard bits
    localparam int ACC_W       = PROD_W + 3;
    localparam int MAG_W       = ACC_W;
    localparam int DIV_CNT_W   = $clog2(MAG_W + 1);
    localparam int CFG_IDX_W   = 3;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;

    localparam coef_t COEF_ONE  = coef_t'(16384);
    localparam coef_t COEF_ZERO = coef_t'(0);

    // operand samples for one output
    typedef struct packed {
        sample_t x;
        sample_t x1;
        sample_t x2;
        sample_t y1;
        sample_t y2;
    } operands_t;

    // multiply taps, divisor excluded
    typedef struct packed {
        coef_t b0;
        coef_t b1;
        coef_t b2;
        coef_t a1;
        coef_t a2;
    } taps_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_A0 = 3'd3,
        REG_A1 = 3'd4,
        REG_A2 = 3'd5
    } cfg_reg_t;

    typedef enum logic [TERM_W-1:0] {
        TERM_B0,
        TERM_B1,
        TERM_B2,
        TERM_A1,
        TERM_A2
    } term_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC_GO,
        ST_MAC,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

>>> rtl/bqf_mac.sv
// digit-serial multiply-accumulate of the five biquad terms
// depends on bqf_pkg
`timescale 1ns / 1ps

module bqf_mac (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  bqf_pkg::operands_t                   ops,
    input  bqf_pkg::taps_t                       taps,
    output logic                                 done,
    output logic signed [bqf_pkg::ACC_W-1:0]     acc
);
    import bqf_pkg::*;

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    term_t                    term_reg, term_next;
    logic [DIGIT_CNT_W-1:0]   digit_reg, digit_next;
    sample_t                  opnd_reg, opnd_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;

    logic signed [NCOEF_W-1:0] tcoef;
    logic [DIGIT_W-1:0]        dig;
    logic signed [DIGIT_W:0]   dval;
    logic signed [PP_W-1:0]    pp;
    logic signed [PROD_W-1:0]  prod_sum;
    logic                      first_digit;
    logic                      last_digit;

    function automatic sample_t term_opnd(term_t t, operands_t o);
        sample_t r;
        case (t)
            TERM_B0: r = o.x;
            TERM_B1: r = o.x1;
            TERM_B2: r = o.x2;
            TERM_A1: r = o.y1;
            TERM_A2: r = o.y2;
            default: r = o.x;
        endcase
        return r;
    endfunction

    // feedback taps enter negated
    always_comb
    begin
        case (term_reg)
            TERM_B0: tcoef = NCOEF_W'(taps.b0);
            TERM_B1: tcoef = NCOEF_W'(taps.b1);
            TERM_B2: tcoef = NCOEF_W'(taps.b2);
            TERM_A1: tcoef = -NCOEF_W'(taps.a1);
            TERM_A2: tcoef = -NCOEF_W'(taps.a2);
            default: tcoef = '0;
        endcase
    end

    // msb digit first: top digit signed, the rest unsigned
    assign first_digit = (digit_reg == '0);
    assign last_digit  = (digit_reg == DIGIT_CNT_W'(NUM_DIGITS - 1));
    assign dig         = opnd_reg[SAMPLE_W-1 -: DIGIT_W];
    assign dval        = first_digit ? {dig[DIGIT_W-1], dig} : {1'b0, dig};
    assign pp          = tcoef * dval;
    assign prod_sum    = (first_digit ? PROD_W'(0) : (prod_reg <<< DIGIT_W)) + PROD_W'(pp);

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        term_next  = term_reg;
        digit_next = digit_reg;
        opnd_next  = opnd_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            term_next  = TERM_B0;
            digit_next = '0;
            opnd_next  = ops.x;
            acc_next   = '0;
        end
        else if (busy_reg)
        begin
            opnd_next = opnd_reg << DIGIT_W;
            if (last_digit)
            begin
                acc_next   = acc_reg + ACC_W'(prod_sum);
                digit_next = '0;
                if (term_reg == TERM_A2)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                else
                begin
                    term_next = term_t'(term_reg + 1'b1);
                    opnd_next = term_opnd(term_t'(term_reg + 1'b1), ops);
                end
            end
            else
            begin
                digit_next = digit_reg + 1'b1;
                prod_next  = prod_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            term_reg  <= TERM_B0;
            digit_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            term_reg  <= term_next;
            digit_reg <= digit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opnd_reg <= opnd_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign done = done_reg;
    assign acc  = acc_reg;

endmodule

>>> rtl/bqf_div.sv
// bit-serial restoring divider, unsigned magnitudes
// depends on bqf_pkg
`timescale 1ns / 1ps

module bqf_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [bqf_pkg::MAG_W-1:0]     dividend,
    input  logic [bqf_pkg::COEF_W-1:0]    divisor,
    output logic                          done,
    output logic [bqf_pkg::MAG_W-1:0]     quotient
);
    import bqf_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [COEF_W-1:0]     rem_reg, rem_next;
    logic [MAG_W-1:0]      quo_reg, quo_next;
    logic [COEF_W-1:0]     dvs_reg, dvs_next;

    logic [COEF_W:0]       shifted;
    logic [COEF_W+1:0]     diff;
    logic                  qbit;

    // one quotient bit per cycle
    assign shifted = {rem_reg, quo_reg[MAG_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};
    assign qbit    = ~diff[COEF_W+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(MAG_W);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? diff[COEF_W-1:0] : shifted[COEF_W-1:0];
            quo_next = {quo_reg[MAG_W-2:0], qbit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/biquad_filter_section.sv
// top level of the direct-form-I biquad filter section
// depends on bqf_pkg, bqf_mac, bqf_div and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// One signed 16-bit sample in, one filtered sample out:
// y = (b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2) / a0, coefficients signed Q2.14.
// The quotient truncates toward zero and saturates to 16 bits. With a0 zero the
// result is 0 with tuser[0] (divide error) set, and the output history takes 0.
// The first sample after reset preloads all four history taps with itself.
// Per sample the five products run four 4-bit digits each through one 17x5
// multiplier, then a restoring divider makes one quotient bit per cycle over
// the 36-bit magnitude; the steps are capture, product start, products,
// divider start, division, saturation and output load. A sample with a0 zero
// goes from capture straight to output load. One sample is in flight at a
// time; the result sits in an output register, so the next sample is taken
// while it waits downstream, and a result that is still waiting when the next
// one is done holds the block until it leaves. Coefficients are written
// through the cfg port, always ready; the user must write them only while
// idle, which the block itself does not enforce.

module biquad_filter_section (
    input  logic                              clk,
    input  logic                              rst_n,
    // input samples
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [bqf_pkg::SAMPLE_W-1:0]      s_axis_tdata,   // [15:0] sample_in
    // filtered samples
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [bqf_pkg::SAMPLE_W-1:0]      m_axis_tdata,   // [15:0] sample_out
    output logic [0:0]                        m_axis_tuser,   // [0] divide_error
    // coefficient writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bqf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bqf_pkg::COEF_W-1:0]        cfg_data
);
    import bqf_pkg::*;

    // coefficient registers
    coef_t b0_reg, b1_reg, b2_reg, a0_reg, a1_reg, a2_reg;

    // filter history and the sample in flight
    sample_t x1_reg, x1_next;
    sample_t x2_reg, x2_next;
    sample_t y1_reg, y1_next;
    sample_t y2_reg, y2_next;
    sample_t x_reg, x_next;
    logic    primed_reg, primed_next;

    // sequencer
    state_t  state_reg, state_next;
    sample_t y_reg, y_next;
    logic    err_reg, err_next;
    logic    neg_reg, neg_next;

    // output slot
    logic    out_valid_reg, out_valid_next;
    sample_t out_data_reg, out_data_next;
    logic    out_err_reg, out_err_next;

    // datapath links
    operands_t               ops;
    taps_t                   taps;
    logic                    mac_start;
    logic                    mac_done;
    logic signed [ACC_W-1:0] mac_acc;
    logic                    div_start;
    logic                    div_done;
    logic [MAG_W-1:0]        acc_mag;
    logic [COEF_W-1:0]       a0_mag;
    logic [MAG_W-1:0]        quotient;
    logic                    in_req;
    logic                    slot_free;

    localparam logic [MAG_W-1:0] POS_LIMIT = MAG_W'((64'd1 << (SAMPLE_W - 1)) - 64'd1);
    localparam logic [MAG_W-1:0] NEG_LIMIT = MAG_W'(64'd1 << (SAMPLE_W - 1));

    // signed saturation of the quotient magnitude
    function automatic sample_t sat_quotient(logic [MAG_W-1:0] q, logic neg);
        sample_t r;
        if (neg)
        begin
            if (q > NEG_LIMIT)
                r = sample_t'(NEG_LIMIT[SAMPLE_W-1:0]);
            else
                r = -sample_t'(q[SAMPLE_W-1:0]);
        end
        else
        begin
            if (q > POS_LIMIT)
                r = sample_t'(POS_LIMIT[SAMPLE_W-1:0]);
            else
                r = sample_t'(q[SAMPLE_W-1:0]);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // coefficient port, takes a write every cycle, unknown indexes dropped
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_reg <= COEF_ONE;
            b1_reg <= COEF_ZERO;
            b2_reg <= COEF_ZERO;
            a0_reg <= COEF_ONE;
            a1_reg <= COEF_ZERO;
            a2_reg <= COEF_ZERO;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_B0:  b0_reg <= coef_t'(cfg_data);
                REG_B1:  b1_reg <= coef_t'(cfg_data);
                REG_B2:  b2_reg <= coef_t'(cfg_data);
                REG_A0:  a0_reg <= coef_t'(cfg_data);
                REG_A1:  a1_reg <= coef_t'(cfg_data);
                REG_A2:  a2_reg <= coef_t'(cfg_data);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // datapath units
    // ------------------------------------------------------------------
    assign ops  = '{x: x_reg, x1: x1_reg, x2: x2_reg, y1: y1_reg, y2: y2_reg};
    assign taps = '{b0: b0_reg, b1: b1_reg, b2: b2_reg, a1: a1_reg, a2: a2_reg};

    bqf_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mac_start),
        .ops   (ops),
        .taps  (taps),
        .done  (mac_done),
        .acc   (mac_acc)
    );

    // sign handled outside the divider
    assign acc_mag = mac_acc[ACC_W-1] ? MAG_W'(-mac_acc) : MAG_W'(mac_acc);
    assign a0_mag  = a0_reg[COEF_W-1] ? COEF_W'(-a0_reg) : COEF_W'(a0_reg);

    bqf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_mag),
        .divisor  (a0_mag),
        .done     (div_done),
        .quotient (quotient)
    );

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_req        = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        x1_next        = x1_reg;
        x2_next        = x2_reg;
        y1_next        = y1_reg;
        y2_next        = y2_reg;
        primed_next    = primed_reg;
        y_next         = y_reg;
        err_next       = err_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_err_next   = out_err_reg;
        mac_start      = 1'b0;
        div_start      = 1'b0;

        // downstream took the result
        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_req)
                begin
                    x_next = sample_t'(s_axis_tdata);
                    // first sample fills the whole history
                    if (!primed_reg)
                    begin
                        x1_next     = sample_t'(s_axis_tdata);
                        x2_next     = sample_t'(s_axis_tdata);
                        y1_next     = sample_t'(s_axis_tdata);
                        y2_next     = sample_t'(s_axis_tdata);
                        primed_next = 1'b1;
                    end
                    if (a0_reg == COEF_ZERO)
                    begin
                        // divide error: no arithmetic, zero result
                        y_next     = '0;
                        err_next   = 1'b1;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        err_next   = 1'b0;
                        state_next = ST_MAC_GO;
                    end
                end
            end
            ST_MAC_GO:
            begin
                // history is settled now, start the products
                mac_start  = 1'b1;
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                if (mac_done)
                begin
                    div_start  = 1'b1;
                    neg_next   = mac_acc[ACC_W-1] ^ a0_reg[COEF_W-1];
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    y_next     = sat_quotient(quotient, neg_reg);
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // hand over and shift history in one step
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = y_reg;
                    out_err_next   = err_reg;
                    x2_next        = x1_reg;
                    x1_next        = x_reg;
                    y2_next        = y1_reg;
                    y1_next        = y_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            primed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            x1_reg        <= '0;
            x2_reg        <= '0;
            y1_reg        <= '0;
            y2_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            primed_reg    <= primed_next;
            out_valid_reg <= out_valid_next;
            x1_reg        <= x1_next;
            x2_reg        <= x2_next;
            y1_reg        <= y1_next;
            y2_reg        <= y2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        err_reg      <= err_next;
        neg_reg      <= neg_next;
        out_data_reg <= out_data_next;
        out_err_reg  <= out_err_next;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_err_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `BQF_ASSERT_NXT(a_zero_div_skips, clk, rst_n,
        in_req && (a0_reg == COEF_ZERO), (state_reg == ST_OUT) && err_reg,
        "zero divisor request did not go straight to output")
    `BQF_ASSERT_IMP(a_mac_done_waited, clk, rst_n,
        mac_done, state_reg == ST_MAC,
        "mac finished outside its wait state")
    `BQF_ASSERT_IMP(a_div_done_waited, clk, rst_n,
        div_done, state_reg == ST_DIV,
        "divider finished outside its wait state")
    `BQF_ASSERT_NXT(a_out_holds, clk, rst_n,
        (state_reg == ST_OUT) && out_valid_reg && !m_axis_tready, state_reg == ST_OUT,
        "result handed over while output slot was full")
    `BQF_ASSERT_IMP(a_err_zero, clk, rst_n,
        m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0,
        "divide error with nonzero sample")

endmodule

>>> bench/tb_top.sv
// self-checking bench for the biquad filter section: directed table, then random phases
// depends on bqf_pkg and biquad_filter_section; needs no files or arguments at run time
`timescale 1ns / 1ps

module tb_top;

    import bqf_pkg::*;

    // extremes of samples and coefficients
    localparam sample_t SMP_MAX  = 16'sh7FFF;
    localparam sample_t SMP_MIN  = 16'sh8000;
    localparam coef_t   COEF_MAX = 16'sh7FFF;
    localparam coef_t   COEF_MIN = 16'sh8000;

    // register indexes past the last coefficient, writes there are dropped
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

    localparam int NUM_REGS  = 6;
    localparam int LONG_HOLD = 400;     // cycles the sink refuses results once
    localparam int PHASES    = 9;
    localparam int PHASE_LEN = 50;      // samples per random phase
    localparam int DIR_ROWS  = 32;

    // one filtered sample as it leaves the block
    typedef struct packed {
        sample_t y;
        logic    err;
    } filt_result_t;

    typedef enum logic {
        ROW_CFG,
        ROW_SAMPLE
    } row_kind_t;

    // directed row: a coefficient write or a sample, optionally with a pinned result
    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [15:0]           val;
        logic                  pinned;
        sample_t               y;
        logic                  err;
    } dir_row_t;

    typedef enum logic [2:0] {
        STYLE_MILD,
        STYLE_FULL,
        STYLE_TOP,
        STYLE_BOTTOM,
        STYLE_NO_DIV,
        STYLE_TINY_DIV
    } phase_style_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [SAMPLE_W-1:0]   s_axis_tdata;    // [15:0] sample_in
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [SAMPLE_W-1:0]   m_axis_tdata;    // [15:0] sample_out
    logic [0:0]            m_axis_tuser;    // [0] divide_error
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [COEF_W-1:0]     cfg_data;

    biquad_filter_section u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------
    // filter model: coefficient copy, tap history and priming flag
    // ------------------------------------------------------------------
    coef_t   cf_b0 = COEF_ONE;
    coef_t   cf_b1 = COEF_ZERO;
    coef_t   cf_b2 = COEF_ZERO;
    coef_t   cf_a0 = COEF_ONE;
    coef_t   cf_a1 = COEF_ZERO;
    coef_t   cf_a2 = COEF_ZERO;
    sample_t x_tap1 = '0;
    sample_t x_tap2 = '0;
    sample_t y_tap1 = '0;
    sample_t y_tap2 = '0;
    bit      taps_primed = 1'b0;

    // filtered samples still owed by the block, oldest first
    filt_result_t pending_out [$];

    int mismatch_cnt = 0;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_requests = 0;

    // random phases: coefficient flavor per phase, extremes included
    phase_style_t phase_plan [PHASES] = '{
        STYLE_MILD, STYLE_FULL, STYLE_TOP,
        STYLE_MILD, STYLE_NO_DIV, STYLE_TINY_DIV,
        STYLE_MILD, STYLE_BOTTOM, STYLE_FULL
    };

    // directed stimulus; pinned rows carry a result readable by hand
    dir_row_t directed [DIR_ROWS] = '{
        // taps set before the first sample, so priming shows in the output:
        // (1 + 0.5 + 0.25 + 0.5 - 0.25) * 1000 = 2000
        '{ROW_CFG,    REG_B1,       16'd8192,     1'b0, 16'sd0,    1'b0},
        '{ROW_CFG,    REG_B2,       16'd4096,     1'b0, 16'sd0,    1'b0},
        '{ROW_CFG,    REG_A1,       -16'sd8192,   1'b0, 16'sd0,    1'b0},
        '{ROW_CFG,    REG_A2,       16'd4096,     1'b0, 16'sd0,    1'b0},
        '{ROW_SAMPLE, REG_B0,       16'd1000,     1'b1, 16'sd2000, 1'b0},
        '{ROW_SAMPLE, REG_B0,       -16'sd700,    1'b0, 16'sd0,    1'b0},
        '{ROW_SAMPLE, REG_B0,       SMP_MAX,      1'b0, 16'sd0,    1'b0},
        '{ROW_SAMPLE, REG_B0,       SMP_MIN,      1'b0, 16'sd0,    1'b0},
        // back to a plain pass-through
        '{ROW_CFG,    REG_B1,       COEF_ZERO,    1'b0, 16'sd0,    1'b0},
        '{ROW_CFG,    REG_B2,       COEF_ZERO,    1'b0, 16'sd0,    1'b0},
        '{ROW_CFG,    REG_A1,       COEF_ZERO,    1'b0, 16'sd0,    1'b0},
        '{ROW_CFG,    REG_A2,       COEF_ZERO,    1'b0, 16'sd0,    1'b0},
        '{ROW_SAMPLE, REG_B0,       SMP_MAX,      1'b1, SMP_MAX,   1'b0},
        '{ROW_SAMPLE, REG_B0,       SMP_MIN,      1'b1, SMP_MIN,   1'b0},
        '{ROW_SAMPLE, REG_B0,       16'd0,        1'b1, 16'sd0,    1'b0},
        // zero divisor forces 0 with the error flag
        '{ROW_CFG,    REG_A0,       COEF_ZERO,    1'b0, 16'sd0,    1'b0},
        '{ROW_SAMPLE, REG_B0,       16'd500,      1'b1, 16'sd0,    1'b1},
        '{ROW_SAMPLE, REG_B0,       SMP_MIN,      1'b1, 16'sd0,    1'b1},
        // tiny divisor pushes the quotient past both rails
        '{ROW_CFG,    REG_A0,       16'd1,        1'b0, 16'sd0,    1'b0},
        '{ROW_SAMPLE, REG_B0,       16'd2,        1'b1, SMP_MAX,   1'b0},
        '{ROW_SAMPLE, REG_B0,       -16'sd3,      1'b1, SMP_MIN,   1'b0},
        // most negative divisor against largest gain
        '{ROW_CFG,    REG_A0,       COEF_MIN,     1'b0, 16'sd0,    1'b0},
        '{ROW_CFG,    REG_B0,       COEF_MAX,     1'b0, 16'sd0,    1'b0},
        '{ROW_SAMPLE, REG_B0,       SMP_MIN,      1'b1, SMP_MAX,   1'b0},
        '{ROW_SAMPLE, REG_B0,       SMP_MAX,      1'b0, 16'sd0,    1'b0},
        // writes past the last register must change nothing
        '{ROW_CFG,    IDX_SPARE_LO, 16'h0000,     1'b0, 16'sd0,    1'b0},
        '{ROW_CFG,    IDX_SPARE_HI, 16'hFFFF,     1'b0, 16'sd0,    1'b0},
        '{ROW_SAMPLE, REG_B0,       16'hFFFF,     1'b0, 16'sd0,    1'b0},
        // feedback taps at their extremes
        '{ROW_CFG,    REG_A1,       COEF_MIN,     1'b0, 16'sd0,    1'b0},
        '{ROW_CFG,    REG_A2,       COEF_MAX,     1'b0, 16'sd0,    1'b0},
        '{ROW_SAMPLE, REG_B0,       16'd12345,    1'b0, 16'sd0,    1'b0},
        '{ROW_SAMPLE, REG_B0,       -16'sd12345,  1'b0, 16'sd0,    1'b0}
    };

    // one filter step: prime on the first sample, divide, saturate, shift taps
    function automatic filt_result_t filter_step(input sample_t x);
        filt_result_t res;
        longint       acc;
        longint       quot;
        if (!taps_primed) begin
            x_tap1 = x;
            x_tap2 = x;
            y_tap1 = x;
            y_tap2 = x;
            taps_primed = 1'b1;
        end
        if (cf_a0 == COEF_ZERO) begin
            res.y   = '0;
            res.err = 1'b1;
        end else begin
            acc = longint'(cf_b0) * longint'(x)
                + longint'(cf_b1) * longint'(x_tap1)
                + longint'(cf_b2) * longint'(x_tap2)
                - longint'(cf_a1) * longint'(y_tap1)
                - longint'(cf_a2) * longint'(y_tap2);
            // signed division truncates toward zero
            quot = acc / longint'(cf_a0);
            if (quot > longint'(SMP_MAX))
                res.y = SMP_MAX;
            else if (quot < longint'(SMP_MIN))
                res.y = SMP_MIN;
            else
                res.y = sample_t'(quot);
            res.err = 1'b0;
        end
        x_tap2 = x_tap1;
        x_tap1 = x;
        y_tap2 = y_tap1;
        y_tap1 = res.y;
        return res;
    endfunction

    // mirror a coefficient write; unknown indexes are dropped
    function automatic void load_coef(input logic [CFG_IDX_W-1:0] idx, input coef_t val);
        case (idx)
            REG_B0:  cf_b0 = val;
            REG_B1:  cf_b1 = val;
            REG_B2:  cf_b2 = val;
            REG_A0:  cf_a0 = val;
            REG_A1:  cf_a1 = val;
            REG_A2:  cf_a2 = val;
            default: ;
        endcase
    endfunction

    function automatic coef_t coef_between(input int lo, input int hi);
        return coef_t'(lo + int'($urandom_range(hi - lo)));
    endfunction

    // rails, small values near zero, and full-range noise
    function automatic sample_t pick_sample();
        case ($urandom_range(9))
            0:       return SMP_MAX;
            1:       return SMP_MIN;
            2, 3, 4: return sample_t'(int'($urandom_range(511)) - 256);
            default: return sample_t'($urandom);
        endcase
    endfunction

    task automatic report_bad(input string what, input int exp_v, input int act_v);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("mismatch %s: expected %0d, got %0d at %0t ns", what, exp_v, act_v,
                     $time);
    endtask

    // ------------------------------------------------------------------
    // request helpers
    // ------------------------------------------------------------------

    // offer one sample; valid stays high on return so back-to-back requests
    // never drop it, the caller lowers it at the end of a batch
    task automatic send_sample(input sample_t smp, input logic pinned,
                               input sample_t pin_y, input logic pin_err);
        filt_result_t want;
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(90, 1)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        do @(posedge clk); while (!s_axis_tready);
        want = filter_step(smp);
        if (pinned) begin
            want.y   = pin_y;
            want.err = pin_err;
        end
        pending_out.push_back(want);
    endtask

    // one coefficient write; cfg_valid is left high for the next one
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input coef_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        load_coef(idx, val);
    endtask

    // writes go in only with no sample in flight
    task automatic wait_drained();
        while (pending_out.size() != 0) @(posedge clk);
    endtask

    // full coefficient set for one random phase, plus a dropped write
    task automatic program_phase(input phase_style_t style, input logic spare_hi);
        coef_t     vals [NUM_REGS];
        cfg_reg_t  r;
        case (style)
            STYLE_MILD, STYLE_TINY_DIV:
            begin
                vals[REG_B0] = coef_between(-16384, 16384);
                vals[REG_B1] = coef_between(-8192, 8192);
                vals[REG_B2] = coef_between(-8192, 8192);
                vals[REG_A0] = coef_between(8192, 32767);
                if ($urandom_range(3) == 0)
                    vals[REG_A0] = -vals[REG_A0];
                vals[REG_A1] = coef_between(-12000, 12000);
                vals[REG_A2] = coef_between(-4000, 6000);
                // divisor of a few lsb: quotient rides the rails
                if (style == STYLE_TINY_DIV)
                    vals[REG_A0] = ($urandom_range(1) == 0) ? coef_between(1, 3)
                                                            : coef_between(-3, -1);
            end
            STYLE_TOP:
            begin
                foreach (vals[i]) vals[i] = COEF_MAX;
            end
            STYLE_BOTTOM:
            begin
                foreach (vals[i]) vals[i] = COEF_MIN;
            end
            default:
            begin
                foreach (vals[i]) vals[i] = coef_t'($urandom);
                if (style == STYLE_NO_DIV)
                    vals[REG_A0] = COEF_ZERO;
            end
        endcase
        cfg_write(spare_hi ? IDX_SPARE_HI : IDX_SPARE_LO, coef_t'($urandom));
        r = r.first();
        do
        begin
            cfg_write(r, vals[r]);
            r = r.next();
        end
        while (r != r.first());
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // clock, run limit, sink and result check
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // generous ceiling: several times the slowest legal run
    initial
    begin
        #6_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // sink side: random back-pressure, plus one long hold-off on request
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // every accepted result against the oldest pending one
    always @(posedge clk)
    begin
        filt_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_out.size() == 0) begin
                report_bad("result with nothing pending", 0, sample_t'(m_axis_tdata));
            end else begin
                want = pending_out.pop_front();
                if (m_axis_tdata !== want.y)
                    report_bad("sample_out", want.y, sample_t'(m_axis_tdata));
                if (m_axis_tuser[0] !== want.err)
                    report_bad("divide_error", want.err, m_axis_tuser[0]);
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int spin;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        send_idle_pct <= 22;
        recv_idle_pct <= 49;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: writes wait for an empty pipe, samples stream
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (directed[r].kind == ROW_CFG) begin
                s_axis_tvalid <= 1'b0;
                wait_drained();
                cfg_write(directed[r].idx, coef_t'(directed[r].val));
            end else begin
                cfg_valid <= 1'b0;
                send_sample(sample_t'(directed[r].val), directed[r].pinned,
                            directed[r].y, directed[r].err);
            end
        end
        s_axis_tvalid <= 1'b0;
        cfg_valid     <= 1'b0;

        // random phases: sink-heavy idling, then source-heavy, then none
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            case (ph / 3)
                0:
                begin
                    send_idle_pct <= 22;
                    recv_idle_pct <= 49;
                end
                1:
                begin
                    send_idle_pct <= 49;
                    recv_idle_pct <= 22;
                end
                default:
                begin
                    send_idle_pct <= 0;
                    recv_idle_pct <= 0;
                end
            endcase
            program_phase(phase_plan[ph], ph[0]);
            // sink goes quiet while samples keep coming: input must stall
            if (ph == 6)
                hold_requests <= hold_requests + 1;
            for (int n = 0; n < PHASE_LEN; n++)
                send_sample(pick_sample(), 1'b0, '0, 1'b0);
            s_axis_tvalid <= 1'b0;
        end

        // drain, then stay quiet to catch stray results
        spin = 0;
        while (pending_out.size() != 0 && spin < 20000) begin
            @(posedge clk);
            spin++;
        end
        repeat (80) @(posedge clk);
        if (pending_out.size() != 0)
            report_bad("results never delivered", 0, pending_out.size());

        if (mismatch_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> biquad_filter_section.f
+incdir+rtl
rtl/bqf_pkg.sv
rtl/bqf_mac.sv
rtl/bqf_div.sv
rtl/biquad_filter_section.sv
bench/tb_top.sv
